@@ hw/rtl/hrs_pkg.sv @@
// Shared types, register indexes and shading constants for the relief shader.
package hrs_pkg;

  localparam int HrsMaxWidth   = 512;
  localparam int HrsHeightBits = 9;
  localparam int HrsQueueDepth = 4;
  localparam int PixColW       = 9;
  localparam int PixRowW       = 12;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 13;
  localparam int MaxRows       = 4096;

  localparam int QSunXz     = 2253;
  localparam int QSunY      = 2540;
  localparam int QAmb       = 1843;
  localparam int QGain      = 3072;
  localparam int QReliefLo  = 1024;
  localparam int QReliefHi  = 5530;
  localparam int QWaterBase = 3072;
  localparam int QLandBase  = 2662;
  localparam int QTGain     = 1434;
  localparam int TSpan      = 60;
  localparam int TRecip     = 34953;
  localparam int TRecipSh   = 9;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH = 3'd0,
    CFG_FRAME_ROWS  = 3'd1,
    CFG_SEA_LEVEL   = 3'd2,
    CFG_SAND_BAND   = 3'd3,
    CFG_STONE_BAND  = 3'd4,
    CFG_SNOW_BAND   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [9:0]  frame_width;
    logic [12:0] frame_rows;
    logic [8:0]  sea_level;
    logic [8:0]  sand_band;
    logic [8:0]  stone_band;
    logic [8:0]  snow_band;
  } cfg_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  localparam rgb_t ColWater = '{r: 8'd40,  g: 8'd90,  b: 8'd160};
  localparam rgb_t ColSand  = '{r: 8'd210, g: 8'd195, b: 8'd140};
  localparam rgb_t ColSnow  = '{r: 8'd240, g: 8'd244, b: 8'd250};
  localparam rgb_t ColStone = '{r: 8'd120, g: 8'd118, b: 8'd115};
  localparam rgb_t ColGrass = '{r: 8'd70,  g: 8'd135, b: 8'd60};

endpackage

@@ hw/rtl/hrs_if.sv @@
// Valid/ready channel interfaces for height samples and shaded pixels.
interface hrs_in_if #(parameter int HEIGHT_BITS = 9);
  logic                   valid;
  logic                   ready;
  logic [HEIGHT_BITS-1:0] height_sample;
  modport source (output valid, output height_sample, input ready);
  modport sink (input valid, input height_sample, output ready);
endinterface

interface hrs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [8:0]  pixel_column;
  logic [11:0] pixel_row;
  logic        run_last;
  modport source (output valid, output red, output green, output blue, output pixel_column,
                  output pixel_row, output run_last, input ready);
  modport sink (input valid, input red, input green, input blue, input pixel_column,
                input pixel_row, input run_last, output ready);
endinterface

@@ hw/rtl/hrs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module hrs_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

@@ hw/rtl/hrs_queue.sv @@
// Short register queue between the front end and the shading back end.
module hrs_queue #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      count_q <= count_q + CW'(push) - CW'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue fill count exceeds depth");
endmodule

@@ hw/rtl/hrs_front.sv @@
// Front end: raster position, line store and expansion of a sample into shading jobs.
module hrs_front #(
  parameter int MAX_WIDTH   = 512,
  parameter int HEIGHT_BITS = 9,
  localparam int JobW = 3 * HEIGHT_BITS + 9 + 12 + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hrs_pkg::cfg_t    cfg_i,
  hrs_in_if.sink           in_if,
  output logic             job_valid_o,
  input  logic             job_ready_i,
  output logic [JobW-1:0]  job_o
);
  import hrs_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  typedef struct packed {
    logic [HEIGHT_BITS-1:0] h;
    logic [HEIGHT_BITS-1:0] e;
    logic [HEIGHT_BITS-1:0] s;
    logic [PixColW-1:0]     col;
    logic [PixRowW-1:0]     row;
    logic                   last;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_RD   = 3'b010,
    F_EMIT = 3'b100
  } fstate_e;

  fstate_e                state_q, state_d;
  logic [CW-1:0]          col_q, c_q, c_acc;
  logic [PixRowW-1:0]     row_q, r_q, r_acc;
  logic [HEIGHT_BITS-1:0] x_q, left_q, ul_q, above_q, lft_q, upl_q, rdata;
  logic [3:0]             mask_q, mask_new, rest;
  logic [CW:0]            wlim;
  logic [12:0]            hlim;
  logic                   oof, right, bottom, accept, push;
  job_t                   job;

  always_comb begin
    if (cfg_i.frame_width == '0) begin
      wlim = (CW + 1)'(1);
    end else if (14'(cfg_i.frame_width) > 14'(MAX_WIDTH)) begin
      wlim = (CW + 1)'(MAX_WIDTH);
    end else begin
      wlim = (CW + 1)'(cfg_i.frame_width);
    end
    if (cfg_i.frame_rows == '0) begin
      hlim = 13'd1;
    end else if (cfg_i.frame_rows > 13'(MaxRows)) begin
      hlim = 13'(MaxRows);
    end else begin
      hlim = cfg_i.frame_rows;
    end
  end

  assign oof    = ({1'b0, col_q} >= wlim) || ({1'b0, row_q} >= hlim);
  assign c_acc  = oof ? '0 : col_q;
  assign r_acc  = oof ? '0 : row_q;
  assign right  = ({1'b0, c_q} == wlim - 1'b1);
  assign bottom = ({1'b0, r_q} == hlim - 1'b1);
  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == F_IDLE);

  assign mask_new = {bottom && right, bottom && (c_q != '0),
                     (r_q != '0) && right, (r_q != '0) && (c_q != '0)};

  hrs_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(MAX_WIDTH)) u_line (
    .clk_i  (clk_i),
    .we_i   (state_q == F_RD),
    .waddr_i(c_q),
    .wdata_i(x_q),
    .re_i   (accept),
    .raddr_i(c_acc),
    .rdata_o(rdata)
  );

  assign rest = mask_q & (mask_q - 4'd1);

  always_comb begin
    job = '0;
    if (mask_q[0]) begin
      job = '{h: upl_q, e: above_q, s: lft_q, col: PixColW'(c_q - 1'b1),
              row: r_q - 1'b1, last: 1'b0};
    end else if (mask_q[1]) begin
      job = '{h: above_q, e: above_q, s: x_q, col: PixColW'(c_q),
              row: r_q - 1'b1, last: 1'b0};
    end else if (mask_q[2]) begin
      job = '{h: lft_q, e: x_q, s: lft_q, col: PixColW'(c_q - 1'b1),
              row: r_q, last: 1'b0};
    end else begin
      job = '{h: x_q, e: x_q, s: x_q, col: PixColW'(c_q), row: r_q, last: 1'b0};
    end
    job.last = (rest == '0);
  end

  assign job_o       = job;
  assign job_valid_o = (state_q == F_EMIT);
  assign push        = job_valid_o && job_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (accept) state_d = F_RD;
      F_RD:   state_d = (mask_new == '0) ? F_IDLE : F_EMIT;
      F_EMIT: if (push && rest == '0) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= in_if.height_sample;
      c_q <= c_acc;
      r_q <= r_acc;
    end
    if (state_q == F_RD) begin
      above_q <= rdata;
      lft_q   <= left_q;
      upl_q   <= ul_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      left_q  <= '0;
      ul_q    <= '0;
      mask_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == F_RD) begin
        left_q <= x_q;
        ul_q   <= rdata;
        mask_q <= mask_new;
        if (right) begin
          col_q <= '0;
          row_q <= bottom ? '0 : r_q + 1'b1;
        end else begin
          col_q <= c_q + 1'b1;
          row_q <= r_q;
        end
      end else if (push) begin
        mask_q <= rest;
      end
    end
  end

  a_emit_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == F_EMIT |-> mask_q != '0)
    else $error("emit state without pending job");
endmodule

@@ hw/rtl/hrs_back.sv @@
// Back end: hillshade, color band and channel scaling for one pixel at a time.
module hrs_back #(
  parameter int HEIGHT_BITS = 9,
  localparam int JobW = 3 * HEIGHT_BITS + 9 + 12 + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hrs_pkg::cfg_t   cfg_i,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  logic [JobW-1:0] job_i,
  hrs_out_if.source       out_if
);
  import hrs_pkg::*;

  localparam int DW = HEIGHT_BITS + 1;
  localparam int SW = 2 * HEIGHT_BITS + 2;
  localparam int PW = SW + 34;
  localparam int NW = HEIGHT_BITS + 15;
  localparam int LW = HEIGHT_BITS + 18;

  typedef struct packed {
    logic [HEIGHT_BITS-1:0] h;
    logic [HEIGHT_BITS-1:0] e;
    logic [HEIGHT_BITS-1:0] s;
    logic [PixColW-1:0]     col;
    logic [PixRowW-1:0]     row;
    logic                   last;
  } job_t;

  typedef enum logic [6:0] {
    B_IDLE  = 7'b0000001,
    B_TL    = 7'b0000010,
    B_ROOT  = 7'b0000100,
    B_LAM   = 7'b0001000,
    B_REL   = 7'b0010000,
    B_LIFT  = 7'b0100000,
    B_COLOR = 7'b1000000
  } bstate_e;

  bstate_e             state_q;
  job_t                job_in, job_q;
  logic signed [DW-1:0] dx_q, dz_q;
  logic signed [DW:0]  dsum;
  logic signed [2*DW-1:0] sqx, sqz;
  logic [SW-1:0]       s_d;
  logic [PW-1:0]       p_q, a_q, b_q, trial;
  logic [15:0]         bit_q, rs_q;
  logic signed [NW-1:0] num_q;
  logic signed [NW+16:0] prod;
  logic signed [LW-1:0] lam_q, rsum;
  logic signed [LW+13:0] m2;
  logic [12:0]         rel_q, t_q;
  logic [10:0]         tl_q;
  logic [13:0]         lift_q;
  logic [25:0]         lmul;
  logic [5:0]          hm;
  logic [21:0]         tmul;
  logic [16:0]         hx, sand_top;
  logic                water_q, water_d, go, out_valid_q;
  rgb_t                base_q, base_d;
  logic [21:0]         cr, cg, cb;

  assign job_in = job_i;
  assign job_ready_o = (state_q == B_IDLE);

  assign hx       = 17'(job_in.h);
  assign sand_top = 17'(cfg_i.sea_level) + 17'(cfg_i.sand_band);
  always_comb begin
    water_d = 1'b0;
    if (hx <= 17'(cfg_i.sea_level)) begin
      base_d  = ColWater;
      water_d = 1'b1;
    end else if (hx <= sand_top) begin
      base_d = ColSand;
    end else if (hx >= 17'(cfg_i.snow_band)) begin
      base_d = ColSnow;
    end else if (hx >= 17'(cfg_i.stone_band)) begin
      base_d = ColStone;
    end else begin
      base_d = ColGrass;
    end
  end

  assign hm   = (hx > 17'(TSpan)) ? 6'(TSpan) : 6'(job_in.h);
  assign tmul = 22'(hm) * 22'(TRecip);

  assign sqx  = dx_q * dx_q;
  assign sqz  = dz_q * dz_q;
  assign s_d  = SW'($unsigned(sqx)) + SW'($unsigned(sqz)) + SW'(1);
  assign dsum = DW'(dx_q) + DW'(dz_q) + (DW + 1)'(0);

  assign trial = p_q + a_q + b_q;
  assign prod  = (NW + 17)'(num_q) * $signed({1'b0, rs_q});
  assign m2    = (LW + 14)'(lam_q) * (LW + 14)'(QGain);
  assign rsum  = LW'(m2 >>> 12) + LW'(QAmb);
  assign lmul  = 26'(13'(QLandBase) + 13'(tl_q)) * 26'(rel_q);

  assign go = !out_valid_q || out_if.ready;
  assign cr = 22'(base_q.r) * 22'(lift_q);
  assign cg = 22'(base_q.g) * 22'(lift_q);
  assign cb = 22'(base_q.b) * 22'(lift_q);

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: if (job_valid_i) begin
        job_q   <= job_in;
        dx_q    <= $signed({1'b0, job_in.e}) - $signed({1'b0, job_in.h});
        dz_q    <= $signed({1'b0, job_in.s}) - $signed({1'b0, job_in.h});
        t_q     <= 13'(tmul >> TRecipSh);
        water_q <= water_d;
        base_q  <= base_d;
      end
      B_TL: begin
        tl_q  <= 11'((24'(t_q) * 24'(QTGain)) >> 12);
        num_q <= NW'(dsum) * NW'(QSunXz) + NW'(QSunY);
        p_q   <= '0;
        a_q   <= '0;
        b_q   <= PW'(s_d) << 30;
        bit_q <= 16'h8000;
        rs_q  <= '0;
      end
      B_ROOT: begin
        if (trial <= (PW'(1) << 30)) begin
          p_q  <= trial;
          a_q  <= (a_q >> 1) + b_q;
          rs_q <= rs_q | bit_q;
        end else begin
          a_q <= a_q >> 1;
        end
        b_q   <= b_q >> 2;
        bit_q <= bit_q >> 1;
      end
      B_LAM: lam_q <= LW'(prod >>> 15);
      B_REL: begin
        if (rsum < LW'(QReliefLo)) begin
          rel_q <= 13'(QReliefLo);
        end else if (rsum > LW'(QReliefHi)) begin
          rel_q <= 13'(QReliefHi);
        end else begin
          rel_q <= 13'(rsum);
        end
      end
      B_LIFT: lift_q <= water_q ? 14'(QWaterBase) + 14'(tl_q) : 14'(lmul >> 12);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_COLOR && go) begin
      out_if.red          <= (cr[21:12] > 10'd255) ? 8'd255 : cr[19:12];
      out_if.green        <= (cg[21:12] > 10'd255) ? 8'd255 : cg[19:12];
      out_if.blue         <= (cb[21:12] > 10'd255) ? 8'd255 : cb[19:12];
      out_if.pixel_column <= job_q.col;
      out_if.pixel_row    <= job_q.row;
      out_if.run_last     <= job_q.last;
    end
  end

  assign out_if.valid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE:  if (job_valid_i) state_q <= B_TL;
        B_TL:    state_q <= water_q ? B_LIFT : B_ROOT;
        B_ROOT:  if (bit_q[0]) state_q <= B_LAM;
        B_LAM:   state_q <= B_REL;
        B_REL:   state_q <= B_LIFT;
        B_LIFT:  state_q <= B_COLOR;
        B_COLOR: if (go) begin
          state_q     <= B_IDLE;
          out_valid_q <= 1'b1;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  a_root_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_ROOT && bit_q[0] |=> state_q == B_LAM)
    else $error("root iteration did not finish after last bit");
  a_rel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_LIFT && !water_q |-> rel_q >= 13'(QReliefLo) && rel_q <= 13'(QReliefHi))
    else $error("relief outside clamp range");
  a_water_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_REL |-> !water_q)
    else $error("water pixel entered relief path");
endmodule

@@ hw/rtl/heightfield_relief_shader_top.sv @@
// Top level of the terrain relief shader: config registers, front end, queue, back end.
//
// Heights enter on in_if in raster order, one beat per column. Each beat yields zero to
// four shaded pixels on out_if, the last one flagged by run_last; a pixel is emitted once
// its south neighbour has arrived, so the bottom row and right edge give extra beats.
// The front end takes a sample only while idle, then does a line store read and write-back,
// and pushes the pixel jobs it spawns into a 4-entry queue before it takes the next sample.
// The back end shades one pixel at a time; land pixels run the 16-step shift-and-add reciprocal
// square root between B_TL and B_LAM, while water pixels go from B_TL straight to B_LIFT.
// A finished pixel sits in the output register while the next one is shaded; when the
// receiver stalls the back end holds, the queue fills, then in_if.ready drops.
// Reset returns to column 0, row 0 and the register defaults; line store contents are
// not cleared and row 0 never reads them. Write configuration through cfg_we_i only
// while the block is idle.
module heightfield_relief_shader_top #(
  parameter int MAX_WIDTH   = hrs_pkg::HrsMaxWidth,
  parameter int HEIGHT_BITS = hrs_pkg::HrsHeightBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hrs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hrs_pkg::CfgDataW-1:0] cfg_data_i,
  hrs_in_if.sink                       in_if,
  hrs_out_if.source                    out_if
);
  import hrs_pkg::*;

  localparam int JobW = 3 * HEIGHT_BITS + 9 + 12 + 1;

  cfg_t            cfg_q;
  logic            fq_valid, fq_ready, qb_valid, qb_ready;
  logic [JobW-1:0] fq_data, qb_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{frame_width: 10'd512, frame_rows: 13'd512, sea_level: 9'd24,
                 sand_band: 9'd2, stone_band: 9'd48, snow_band: 9'd56};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH: cfg_q.frame_width <= cfg_data_i[9:0];
        CFG_FRAME_ROWS:  cfg_q.frame_rows  <= cfg_data_i[12:0];
        CFG_SEA_LEVEL:   cfg_q.sea_level   <= cfg_data_i[8:0];
        CFG_SAND_BAND:   cfg_q.sand_band   <= cfg_data_i[8:0];
        CFG_STONE_BAND:  cfg_q.stone_band  <= cfg_data_i[8:0];
        CFG_SNOW_BAND:   cfg_q.snow_band   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  hrs_front #(.MAX_WIDTH(MAX_WIDTH), .HEIGHT_BITS(HEIGHT_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_if      (in_if),
    .job_valid_o(fq_valid),
    .job_ready_i(fq_ready),
    .job_o      (fq_data)
  );

  hrs_queue #(.WIDTH(JobW), .DEPTH(HrsQueueDepth)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fq_valid),
    .push_ready_o(fq_ready),
    .push_data_i (fq_data),
    .pop_valid_o (qb_valid),
    .pop_ready_i (qb_ready),
    .pop_data_o  (qb_data)
  );

  hrs_back #(.HEIGHT_BITS(HEIGHT_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .job_valid_i(qb_valid),
    .job_ready_o(qb_ready),
    .job_i      (qb_data),
    .out_if     (out_if)
  );
endmodule

@@ sim/heightfield_relief_shader_top_tb.sv @@
// Testbench for the relief shader: predicts every shaded pixel and checks each output beat.
module heightfield_relief_shader_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hrs_pkg::*;

  localparam longint CycleLimit = 3000000;
  localparam int SettleCycles = 150;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [8:0]  col;
    logic [11:0] row;
    logic        last;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  hrs_in_if #(.HEIGHT_BITS(HrsHeightBits)) in_bus ();
  hrs_out_if out_bus ();

  heightfield_relief_shader_top u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_if(in_bus), .out_if(out_bus)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [9:0]  fw = 10'd512;
  logic [12:0] fr = 13'd512;
  logic [8:0]  sea = 9'd24, sand = 9'd2, stone = 9'd48, snow = 9'd56;
  logic [8:0]  row_buf [HrsMaxWidth];
  logic [8:0]  left_h = '0, upleft_h = '0;
  int          cur_col = 0, cur_row = 0;

  pixel_t pending_pixels[$];
  int     errors = 0;
  longint cycles = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_off = 0;
  int     walk_h = 100;

  function automatic pixel_t shade_pixel(int col, int row, int h, int e, int s);
    longint dx, dz, lim, lo, hi, mid, lam, rel, t, tl, lift, v;
    longint base [3];
    pixel_t p;
    t = ((h < 60 ? h : 60) * 4096) / 60;
    tl = (1434 * t) >>> 12;
    if (h <= sea) begin
      lift = 3072 + tl;
      base = '{40, 90, 160};
    end else begin
      dx = e - h;
      dz = s - h;
      lim = (64'sd1 << 30) / (dx * dx + dz * dz + 1);
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (mid * mid <= lim) lo = mid;
        else hi = mid - 1;
      end
      lam = ((2253 * (dx + dz) + 2540) * lo) >>> 15;
      rel = 1843 + ((3072 * lam) >>> 12);
      if (rel < 1024) rel = 1024;
      if (rel > 5530) rel = 5530;
      lift = ((2662 + tl) * rel) >>> 12;
      if (h <= int'(sea) + int'(sand)) base = '{210, 195, 140};
      else if (h >= snow) base = '{240, 244, 250};
      else if (h >= stone) base = '{120, 118, 115};
      else base = '{70, 135, 60};
    end
    v = (base[0] * lift) >>> 12; p.red = (v > 255) ? 8'd255 : v[7:0];
    v = (base[1] * lift) >>> 12; p.green = (v > 255) ? 8'd255 : v[7:0];
    v = (base[2] * lift) >>> 12; p.blue = (v > 255) ? 8'd255 : v[7:0];
    p.col = col[8:0];
    p.row = row[11:0];
    p.last = 1'b0;
    return p;
  endfunction

  task automatic predict_pixels(input int x);
    int w, hgt, c, r, above, n0;
    logic right, bottom;
    w = (fw < 1) ? 1 : ((fw > HrsMaxWidth) ? HrsMaxWidth : int'(fw));
    hgt = (fr < 1) ? 1 : ((fr > MaxRows) ? MaxRows : int'(fr));
    if (cur_col >= w || cur_row >= hgt) begin
      cur_col = 0;
      cur_row = 0;
    end
    c = cur_col;
    r = cur_row;
    above = row_buf[c];
    right = (c == w - 1);
    bottom = (r == hgt - 1);
    n0 = pending_pixels.size();
    if (r >= 1 && c >= 1) pending_pixels.push_back(shade_pixel(c - 1, r - 1, upleft_h, above, left_h));
    if (r >= 1 && right) pending_pixels.push_back(shade_pixel(c, r - 1, above, above, x));
    if (bottom && c >= 1) pending_pixels.push_back(shade_pixel(c - 1, r, left_h, x, left_h));
    if (bottom && right) pending_pixels.push_back(shade_pixel(c, r, x, x, x));
    if (pending_pixels.size() > n0) pending_pixels[$].last = 1'b1;
    upleft_h = above[8:0];
    row_buf[c] = x[8:0];
    left_h = x[8:0];
    if (right) begin
      cur_col = 0;
      cur_row = bottom ? 0 : r + 1;
    end else begin
      cur_col = c + 1;
    end
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    pixel_t exp_px;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel beat col %0d row %0d", out_bus.pixel_column, out_bus.pixel_row);
        errors++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_bus.red !== exp_px.red) begin
          $error("red: expected %0d, got %0d", exp_px.red, out_bus.red); errors++;
        end
        if (out_bus.green !== exp_px.green) begin
          $error("green: expected %0d, got %0d", exp_px.green, out_bus.green); errors++;
        end
        if (out_bus.blue !== exp_px.blue) begin
          $error("blue: expected %0d, got %0d", exp_px.blue, out_bus.blue); errors++;
        end
        if (out_bus.pixel_column !== exp_px.col) begin
          $error("pixel_column: expected %0d, got %0d", exp_px.col, out_bus.pixel_column);
          errors++;
        end
        if (out_bus.pixel_row !== exp_px.row) begin
          $error("pixel_row: expected %0d, got %0d", exp_px.row, out_bus.pixel_row); errors++;
        end
        if (out_bus.run_last !== exp_px.last) begin
          $error("run_last: expected %0d, got %0d", exp_px.last, out_bus.run_last); errors++;
        end
      end
    end
  end

  task automatic height_beat(input int h);
    int gap;
    @(negedge clk_i);
    in_bus.valid <= 1'b1;
    in_bus.height_sample <= h[8:0];
    do @(posedge clk_i); while (!in_bus.ready);
    predict_pixels(h);
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[CfgDataW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH: fw = val[9:0];
      CFG_FRAME_ROWS:  fr = val[12:0];
      CFG_SEA_LEVEL:   sea = val[8:0];
      CFG_SAND_BAND:   sand = val[8:0];
      CFG_STONE_BAND:  stone = val[8:0];
      CFG_SNOW_BAND:   snow = val[8:0];
      default: ;
    endcase
  endtask

  function automatic int terrain_height();
    if ($urandom_range(99) < 20) return $urandom_range(0, 511);
    walk_h = walk_h + $urandom_range(0, 40) - 20;
    if (walk_h < 0) walk_h = 0;
    if (walk_h > 511) walk_h = 511;
    return walk_h;
  endfunction

  task automatic test_wide_frame();
    write_reg(CFG_FRAME_ROWS, 1);
    for (int i = 0; i < 16; i++) height_beat(terrain_height());
    wait_drained();
  endtask

  task automatic test_band_edges();
    int vals [24] = '{0, 511, 24, 25, 26, 27, 47, 48, 55, 56, 60, 61,
                      511, 0, 511, 0, 511, 0, 59, 1, 2, 300, 128, 255};
    write_reg(CFG_FRAME_WIDTH, 3);
    for (int i = 0; i < 24; i++) height_beat(vals[i]);
    wait_drained();
  endtask

  task automatic test_narrow_extremes();
    write_reg(CFG_FRAME_WIDTH, 0);
    write_reg(CFG_FRAME_ROWS, 3);
    write_reg(CFG_SEA_LEVEL, 511);
    for (int i = 0; i < 6; i++) height_beat($urandom_range(0, 511));
    wait_drained();
    write_reg(CFG_SEA_LEVEL, 0);
    write_reg(CFG_SAND_BAND, 511);
    write_reg(CFG_FRAME_ROWS, 8191);
    for (int i = 0; i < 10; i++) height_beat($urandom_range(0, 511));
    wait_drained();
    write_reg(CFG_SAND_BAND, 0);
    write_reg(CFG_SNOW_BAND, 0);
    write_reg(CFG_STONE_BAND, 511);
    write_reg(CFG_FRAME_ROWS, 1);
    write_reg(CFG_FRAME_WIDTH, 1023);
    for (int i = 0; i < 16; i++) height_beat($urandom_range(0, 511));
    wait_drained();
  endtask

  task automatic test_random_frames();
    int idle_set [4][2] = '{'{0, 0}, '{75, 0}, '{0, 75}, '{30, 30}};
    int w, hgt, sent;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_set[ph][0];
      recv_stall_pct = idle_set[ph][1];
      sent = 0;
      while (sent < 12) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        hgt = $urandom_range(1, 5);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_ROWS, hgt);
        write_reg(CFG_SEA_LEVEL, $urandom_range(0, 120));
        write_reg(CFG_SAND_BAND, $urandom_range(0, 30));
        write_reg(CFG_STONE_BAND, $urandom_range(60, 300));
        write_reg(CFG_SNOW_BAND, $urandom_range(150, 511));
        for (int i = 0; i < w * hgt; i++) height_beat(terrain_height());
        sent += w * hgt;
        wait_drained();
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    write_reg(CFG_FRAME_WIDTH, 4);
    write_reg(CFG_FRAME_ROWS, 5);
    write_reg(CFG_SEA_LEVEL, 24);
    write_reg(CFG_SAND_BAND, 2);
    write_reg(CFG_STONE_BAND, 48);
    write_reg(CFG_SNOW_BAND, 56);
    hold_off = 400;
    for (int i = 0; i < 12; i++) height_beat(terrain_height());
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 8; i++) height_beat(terrain_height());
    wait_drained();
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.height_sample = '0;
    out_bus.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_wide_frame();
    test_band_edges();
    test_narrow_extremes();
    test_random_frames();
    test_backpressure();
    wait_drained();
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
